// File: hw/rtl/pit_pkg.sv
// Shared constants and width helpers for the point-in-triangle test.
// No dependencies; the interfaces, the top level and pit_edge_gram take names from here.
package pit_pkg;

  // Default coordinate width; valid range is 8 to 32 bits.
  localparam int COORD_WIDTH_DEF = 24;

  // Pipeline stage numbering, front to back.
  localparam int ST_DIFF    = 0;  // edge and offset vectors
  localparam int ST_PROD    = 1;  // per-axis products
  localparam int ST_DOT     = 2;  // Gram entries and right-hand side
  localparam int ST_PPROD   = 3;  // partial products of the wide multiplies
  localparam int ST_WPROD   = 4;  // wide products assembled
  localparam int ST_CRAMER  = 5;  // determinant and numerators
  localparam int ST_DECIDE  = 6;  // sign tests, result flags
  localparam int NUM_STAGES = 7;

  // Width of a dot product of two coordinate differences.
  function automatic int dot_width(input int cw);
    return 2 * cw + 4;
  endfunction

endpackage

// File: hw/rtl/pit_if.sv
// Valid/ready channel interfaces for the point-in-triangle test.
// pit_in_if carries one point and triangle per beat, pit_out_if the result flags.
// Depends on pit_pkg for the default coordinate width.
interface pit_in_if #(
  parameter int COORD_WIDTH = pit_pkg::COORD_WIDTH_DEF
);
  logic                          valid;
  logic                          ready;
  logic signed [COORD_WIDTH-1:0] pt_x;
  logic signed [COORD_WIDTH-1:0] pt_y;
  logic signed [COORD_WIDTH-1:0] pt_z;
  logic signed [COORD_WIDTH-1:0] c0_x;
  logic signed [COORD_WIDTH-1:0] c0_y;
  logic signed [COORD_WIDTH-1:0] c0_z;
  logic signed [COORD_WIDTH-1:0] c1_x;
  logic signed [COORD_WIDTH-1:0] c1_y;
  logic signed [COORD_WIDTH-1:0] c1_z;
  logic signed [COORD_WIDTH-1:0] c2_x;
  logic signed [COORD_WIDTH-1:0] c2_y;
  logic signed [COORD_WIDTH-1:0] c2_z;

  modport source (
    output valid, pt_x, pt_y, pt_z, c0_x, c0_y, c0_z,
           c1_x, c1_y, c1_z, c2_x, c2_y, c2_z,
    input  ready
  );
  modport sink (
    input  valid, pt_x, pt_y, pt_z, c0_x, c0_y, c0_z,
           c1_x, c1_y, c1_z, c2_x, c2_y, c2_z,
    output ready
  );
endinterface

interface pit_out_if;
  logic valid;
  logic ready;
  logic inside_res;
  logic degenerate;

  modport source (output valid, inside_res, degenerate, input ready);
  modport sink   (input valid, inside_res, degenerate, output ready);
endinterface

// File: hw/rtl/point_in_triangle_test_top.sv
// Point-in-triangle test, top level: handshake control and datapath wiring.
// Depends on pit_pkg, pit_if, pit_edge_gram, pit_wide_mul and pit_decide.
//
// Each input beat carries a query point and three triangle corners as signed
// COORD_WIDTH-bit integers; each produces exactly one output beat with
// inside_res (the point, projected onto the triangle's plane, lies within the
// triangle or on its edge) and degenerate (the edge Gram determinant is zero;
// inside_res is then 0). The distance of the point from the plane is not
// checked. The block takes one beat per clock and sustains that rate
// indefinitely while the output side keeps taking results; each result passes
// through every stage below in turn and is offered on the output channel from
// the last stage's registers. The
// seven register stages are: coordinate differences, per-axis products, dot
// sums (Gram entries and right-hand side), half-width partial products of the
// six wide multiplies, assembled wide products, determinant and numerators,
// and the final sign tests. All arithmetic is exact two's complement sized to
// the coordinate width, so no rounding ever changes a verdict. Every stage
// keeps its own valid bit; a stage refills whenever it is empty or its
// successor moves, so bubbles close up while the output is stalled, and a
// stall loses or repeats nothing. There is no state between beats and reset
// only clears the valid bits.
module point_in_triangle_test_top #(
  parameter int COORD_WIDTH = pit_pkg::COORD_WIDTH_DEF
) (
  input  logic     clk,
  input  logic     rst,
  pit_in_if.sink   in_ch,
  pit_out_if.source out_ch
);

  localparam int NS = pit_pkg::NUM_STAGES;
  localparam int DW = pit_pkg::dot_width(COORD_WIDTH);
  localparam int PW = 2 * DW;

  // Stage control: vld holds per-stage occupancy.
  logic [NS-1:0] vld;
  logic [NS-1:0] vld_prev;
  logic [NS-1:0] stage_ready;
  logic [NS-1:0] en;

  always_comb begin
    vld_prev = {vld[NS-2:0], in_ch.valid};
    stage_ready[NS-1] = !vld[NS-1] || out_ch.ready;
    for (int i = NS - 2; i >= 0; i--) begin
      stage_ready[i] = !vld[i] || stage_ready[i+1];
    end
    // Load a stage's data only when a live beat moves into it.
    en = stage_ready & vld_prev;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      for (int i = 0; i < NS; i++) begin
        if (stage_ready[i]) begin
          vld[i] <= vld_prev[i];
        end
      end
    end
  end

  assign in_ch.ready  = stage_ready[0];
  assign out_ch.valid = vld[NS-1];

  // Gather coordinates into per-vertex vectors, x, y, z order.
  logic signed [COORD_WIDTH-1:0] pt [3];
  logic signed [COORD_WIDTH-1:0] c0 [3];
  logic signed [COORD_WIDTH-1:0] c1 [3];
  logic signed [COORD_WIDTH-1:0] c2 [3];

  assign pt[0] = in_ch.pt_x;
  assign pt[1] = in_ch.pt_y;
  assign pt[2] = in_ch.pt_z;
  assign c0[0] = in_ch.c0_x;
  assign c0[1] = in_ch.c0_y;
  assign c0[2] = in_ch.c0_z;
  assign c1[0] = in_ch.c1_x;
  assign c1[1] = in_ch.c1_y;
  assign c1[2] = in_ch.c1_z;
  assign c2[0] = in_ch.c2_x;
  assign c2[1] = in_ch.c2_y;
  assign c2[2] = in_ch.c2_z;

  // Gram entries and right-hand side.
  logic signed [DW-1:0] g_a, g_b, g_c, g_r0, g_r1;

  pit_edge_gram #(
    .COORD_WIDTH (COORD_WIDTH)
  ) u_edge_gram (
    .clk (clk),
    .en  (en[pit_pkg::ST_DOT:pit_pkg::ST_DIFF]),
    .pt  (pt),
    .c0  (c0),
    .c1  (c1),
    .c2  (c2),
    .a   (g_a),
    .b   (g_b),
    .c   (g_c),
    .r0  (g_r0),
    .r1  (g_r1)
  );

  // Six wide products for Cramer's rule, all in lockstep.
  logic signed [PW-1:0] p_ac, p_bb, p_r0c, p_br1, p_ar1, p_br0;

  pit_wide_mul #(.IN_WIDTH(DW)) u_mul_ac (
    .clk (clk), .en (en[pit_pkg::ST_WPROD:pit_pkg::ST_PPROD]),
    .x (g_a), .y (g_c), .p (p_ac)
  );

  pit_wide_mul #(.IN_WIDTH(DW)) u_mul_bb (
    .clk (clk), .en (en[pit_pkg::ST_WPROD:pit_pkg::ST_PPROD]),
    .x (g_b), .y (g_b), .p (p_bb)
  );

  pit_wide_mul #(.IN_WIDTH(DW)) u_mul_r0c (
    .clk (clk), .en (en[pit_pkg::ST_WPROD:pit_pkg::ST_PPROD]),
    .x (g_r0), .y (g_c), .p (p_r0c)
  );

  pit_wide_mul #(.IN_WIDTH(DW)) u_mul_br1 (
    .clk (clk), .en (en[pit_pkg::ST_WPROD:pit_pkg::ST_PPROD]),
    .x (g_b), .y (g_r1), .p (p_br1)
  );

  pit_wide_mul #(.IN_WIDTH(DW)) u_mul_ar1 (
    .clk (clk), .en (en[pit_pkg::ST_WPROD:pit_pkg::ST_PPROD]),
    .x (g_a), .y (g_r1), .p (p_ar1)
  );

  pit_wide_mul #(.IN_WIDTH(DW)) u_mul_br0 (
    .clk (clk), .en (en[pit_pkg::ST_WPROD:pit_pkg::ST_PPROD]),
    .x (g_b), .y (g_r0), .p (p_br0)
  );

  // Determinant, numerators and the verdict; output fields come straight
  // from the last stage's registers.
  pit_decide #(
    .PROD_WIDTH (PW)
  ) u_decide (
    .clk        (clk),
    .en         (en[pit_pkg::ST_DECIDE:pit_pkg::ST_CRAMER]),
    .ac         (p_ac),
    .bb         (p_bb),
    .r0c        (p_r0c),
    .br1        (p_br1),
    .ar1        (p_ar1),
    .br0        (p_br0),
    .inside_res (out_ch.inside_res),
    .degenerate (out_ch.degenerate)
  );

endmodule

// File: hw/rtl/pit_edge_gram.sv
// Front three stages: edge/offset vectors, per-axis products, dot sums.
// Produces the Gram entries a, b, c and the right-hand side r0, r1.
// Depends on pit_pkg.
module pit_edge_gram #(
  parameter int COORD_WIDTH = pit_pkg::COORD_WIDTH_DEF
) (
  input  logic                                            clk,
  input  logic [2:0]                                      en,
  input  logic signed [COORD_WIDTH-1:0]                   pt [3],
  input  logic signed [COORD_WIDTH-1:0]                   c0 [3],
  input  logic signed [COORD_WIDTH-1:0]                   c1 [3],
  input  logic signed [COORD_WIDTH-1:0]                   c2 [3],
  output logic signed [pit_pkg::dot_width(COORD_WIDTH)-1:0] a,
  output logic signed [pit_pkg::dot_width(COORD_WIDTH)-1:0] b,
  output logic signed [pit_pkg::dot_width(COORD_WIDTH)-1:0] c,
  output logic signed [pit_pkg::dot_width(COORD_WIDTH)-1:0] r0,
  output logic signed [pit_pkg::dot_width(COORD_WIDTH)-1:0] r1
);

  localparam int DFW = COORD_WIDTH + 1;
  localparam int MW  = 2 * DFW;
  localparam int DW  = pit_pkg::dot_width(COORD_WIDTH);

  logic signed [DFW-1:0] e0 [3];
  logic signed [DFW-1:0] e1 [3];
  logic signed [DFW-1:0] d  [3];

  logic signed [MW-1:0] m_aa [3];
  logic signed [MW-1:0] m_ab [3];
  logic signed [MW-1:0] m_cc [3];
  logic signed [MW-1:0] m_r0 [3];
  logic signed [MW-1:0] m_r1 [3];

  // Differences from corner 0, one bit wider than a coordinate.
  always_ff @(posedge clk) begin
    if (en[0]) begin
      for (int k = 0; k < 3; k++) begin
        e0[k] <= $signed({c1[k][COORD_WIDTH-1], c1[k]}) - $signed({c0[k][COORD_WIDTH-1], c0[k]});
        e1[k] <= $signed({c2[k][COORD_WIDTH-1], c2[k]}) - $signed({c0[k][COORD_WIDTH-1], c0[k]});
        d[k]  <= $signed({pt[k][COORD_WIDTH-1], pt[k]}) - $signed({c0[k][COORD_WIDTH-1], c0[k]});
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      for (int k = 0; k < 3; k++) begin
        m_aa[k] <= e0[k] * e0[k];
        m_ab[k] <= e0[k] * e1[k];
        m_cc[k] <= e1[k] * e1[k];
        m_r0[k] <= e0[k] * d[k];
        m_r1[k] <= e1[k] * d[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[2]) begin
      a  <= DW'(m_aa[0]) + DW'(m_aa[1]) + DW'(m_aa[2]);
      b  <= DW'(m_ab[0]) + DW'(m_ab[1]) + DW'(m_ab[2]);
      c  <= DW'(m_cc[0]) + DW'(m_cc[1]) + DW'(m_cc[2]);
      r0 <= DW'(m_r0[0]) + DW'(m_r0[1]) + DW'(m_r0[2]);
      r1 <= DW'(m_r1[0]) + DW'(m_r1[1]) + DW'(m_r1[2]);
    end
  end

endmodule

// File: hw/rtl/pit_wide_mul.sv
// Two-stage signed multiplier for dot-width operands, split in halves.
// Stage one forms four half-width partial products, stage two sums them.
// No package dependencies.
module pit_wide_mul #(
  parameter int IN_WIDTH = 52
) (
  input  logic                         clk,
  input  logic [1:0]                   en,
  input  logic signed [IN_WIDTH-1:0]   x,
  input  logic signed [IN_WIDTH-1:0]   y,
  output logic signed [2*IN_WIDTH-1:0] p
);

  localparam int H  = IN_WIDTH / 2;      // low half, unsigned
  localparam int HW = IN_WIDTH - H;      // high half, signed
  localparam int PW = 2 * IN_WIDTH;

  logic        [H-1:0]  xl, yl;
  logic signed [HW-1:0] xh, yh;

  logic signed [2*H+1:0]  pp_ll;
  logic signed [H+HW:0]   pp_lh;
  logic signed [H+HW:0]   pp_hl;
  logic signed [2*HW-1:0] pp_hh;

  assign xl = x[H-1:0];
  assign yl = y[H-1:0];
  assign xh = x[IN_WIDTH-1:H];
  assign yh = y[IN_WIDTH-1:H];

  always_ff @(posedge clk) begin
    if (en[0]) begin
      pp_ll <= $signed({1'b0, xl}) * $signed({1'b0, yl});
      pp_lh <= $signed({1'b0, xl}) * yh;
      pp_hl <= xh * $signed({1'b0, yl});
      pp_hh <= xh * yh;
    end
  end

  // The true product fits in PW bits, so wrapping sums stay exact.
  always_ff @(posedge clk) begin
    if (en[1]) begin
      p <= (PW'(pp_hh) << (2 * H)) + ((PW'(pp_lh) + PW'(pp_hl)) << H) + PW'(pp_ll);
    end
  end

endmodule

// File: hw/rtl/pit_decide.sv
// Back two stages: Cramer numerators and determinant, then the inside test.
// Takes the six wide products; registers inside_res and degenerate.
// No package dependencies.
module pit_decide #(
  parameter int PROD_WIDTH = 104
) (
  input  logic                         clk,
  input  logic [1:0]                   en,
  input  logic signed [PROD_WIDTH-1:0] ac,
  input  logic signed [PROD_WIDTH-1:0] bb,
  input  logic signed [PROD_WIDTH-1:0] r0c,
  input  logic signed [PROD_WIDTH-1:0] br1,
  input  logic signed [PROD_WIDTH-1:0] ar1,
  input  logic signed [PROD_WIDTH-1:0] br0,
  output logic                         inside_res,
  output logic                         degenerate
);

  localparam int XW = PROD_WIDTH + 3;

  logic signed [XW-1:0] det, n0, n1;
  logic signed [XW-1:0] slack;

  always_ff @(posedge clk) begin
    if (en[0]) begin
      det <= XW'(ac)  - XW'(bb);
      n0  <= XW'(r0c) - XW'(br1);
      n1  <= XW'(ar1) - XW'(br0);
    end
  end

  // Room left under the determinant; negative means past the far edge.
  assign slack = det - n0 - n1;

  always_ff @(posedge clk) begin
    if (en[1]) begin
      degenerate <= (det == '0);
      inside_res <= (det != '0) && !n0[XW-1] && !n1[XW-1] && !slack[XW-1];
    end
  end

endmodule
